### design/psc_pkg.sv
// shared types and constants for the packed string compare block
`timescale 1ns / 1ps
package psc_pkg;
    localparam int NUM_ELEM = 16;
    localparam int DATA_W = 64;
    localparam int IN_W = 1 + 8 + 4 * DATA_W + 32 + 32;
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W = 5 + 2 * DATA_W + 4;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [1:0] AGG_ANY = 2'd0;
    localparam logic [1:0] AGG_RANGES = 2'd1;
    localparam logic [1:0] AGG_EACH = 2'd2;
    localparam logic [1:0] AGG_ORDERED = 2'd3;

    localparam logic [1:0] POL_NEG_ALL = 2'd1;
    localparam logic [1:0] POL_NEG_VALID = 2'd3;

    // decoded operation carried with each word through the cell row
    typedef struct packed {
        logic       words;
        logic [1:0] agg;
        logic [1:0] pol;
        logic       hisel;
        logic [4:0] la;
        logic [4:0] lb;
    } psc_op_t;

    // signed 17 bit view of element k
    function automatic logic signed [16:0] elem_val(input logic [127:0] v,
                                                     input int k,
                                                     input logic words,
                                                     input logic sgn);
        logic [15:0] w;
        logic [7:0]  b;
        logic signed [16:0] r;
        begin
            w = v[16 * (k % 8) +: 16];
            b = v[8 * k +: 8];
            if (words)
                r = sgn ? 17'(signed'(w)) : signed'({1'b0, w});
            else
                r = sgn ? 17'(signed'(b)) : signed'({9'd0, b});
            return r;
        end
    endfunction
endpackage

### design/psc_cell.sv
// one result element cell: compares its haystack element against the needle
`timescale 1ns / 1ps
module psc_cell
    import psc_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic                   clk,
    input  logic [NUM_ELEM*17-1:0] av,
    input  logic signed [16:0]     bj,
    input  logic [NUM_ELEM-1:0]    eq_ord,
    input  psc_op_t                op,
    output logic                   hit
);
    logic [4:0] n;
    logic       any_hit;
    logic       rng_hit;
    logic       ord_hit;
    logic       hit_next;
    logic       hit_reg;

    always_comb
    begin
        n = op.words ? 5'd8 : 5'd16;
        any_hit = 1'b0;
        rng_hit = 1'b0;
        ord_hit = 1'b1;
        for (int i = 0; i < NUM_ELEM; i++)
        begin
            if (5'(i) < op.la && signed'(av[i*17 +: 17]) == bj)
                any_hit = 1'b1;
            if ((i % 2) == 0 && i + 1 < NUM_ELEM)
                if (5'(i + 1) < op.la && bj >= signed'(av[i*17 +: 17])
                    && bj <= signed'(av[(i+1)*17 +: 17]))
                    rng_hit = 1'b1;
            // eq_ord[i] compares needle i with haystack IDX+i
            if (i + IDX < NUM_ELEM)
                if (5'(i + IDX) < n && 5'(i) < op.la)
                    if (5'(i + IDX) >= op.lb || !eq_ord[i])
                        ord_hit = 1'b0;
        end
        unique case (op.agg)
            AGG_ANY:    hit_next = any_hit && 5'(IDX) < op.lb;
            AGG_RANGES: hit_next = rng_hit && 5'(IDX) < op.lb;
            AGG_EACH:
                if (5'(IDX) < op.la && 5'(IDX) < op.lb)
                    hit_next = signed'(av[IDX*17 +: 17]) == bj;
                else
                    hit_next = 5'(IDX) >= op.la && 5'(IDX) >= op.lb;
            default:    hit_next = ord_hit;
        endcase
        if (5'(IDX) >= n)
            hit_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
    end

    assign hit = hit_reg;
endmodule

### design/psc_finish.sv
// polarity, index search, mask expansion and flags
`timescale 1ns / 1ps
module psc_finish
    import psc_pkg::*;
(
    input  psc_op_t             op,
    input  logic [NUM_ELEM-1:0] res1,
    output logic [4:0]          match_index,
    output logic [63:0]         mask_low,
    output logic [63:0]         mask_high,
    output logic                carry_flag,
    output logic                zero_flag,
    output logic                sign_flag,
    output logic                overflow_flag
);
    logic [4:0]          n;
    logic [15:0]         full;
    logic [15:0]         validb;
    logic [15:0]         res2;
    logic [127:0]        exp_mask;

    always_comb
    begin
        n = op.words ? 5'd8 : 5'd16;
        full = op.words ? 16'h00ff : 16'hffff;
        validb = (op.lb >= n) ? full : 16'((17'd1 << op.lb) - 17'd1);
        case (op.pol)
            POL_NEG_ALL:   res2 = ~res1 & full;
            POL_NEG_VALID: res2 = (res1 ^ validb) & full;
            default:       res2 = res1;
        endcase
        match_index = n;
        for (int k = NUM_ELEM - 1; k >= 0; k--)
            if (res2[k] && !op.hisel)
                match_index = 5'(k);
        if (op.hisel)
            for (int k = 0; k < NUM_ELEM; k++)
                if (res2[k])
                    match_index = 5'(k);
        for (int k = 0; k < NUM_ELEM; k++)
            exp_mask[8*k +: 8] = {8{res2[op.words ? k / 2 : k]}};
        if (op.hisel)
        begin
            mask_low = exp_mask[63:0];
            mask_high = exp_mask[127:64];
        end
        else
        begin
            mask_low = {48'd0, res2};
            mask_high = '0;
        end
        carry_flag = |res2;
        zero_flag = op.lb < n;
        sign_flag = op.la < n;
        overflow_flag = res2[0];
    end
endmodule

### design/packed_string_compare.sv
// top level of the packed string compare block
`timescale 1ns / 1ps
// packed string compare: one compare per word, a new word every cycle while
// s_tready is high. stage one decodes the control byte and finds both
// lengths (zero scan or saturated magnitude of the signed explicit length);
// stage two is a row of sixteen element cells, one per result bit, each
// comparing its haystack element against the needle; the polarity, index and
// mask logic then feeds an output register with a skid stage, and the input
// stays ready while a result waits unless both output slots are full.
module packed_string_compare
    import psc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // action, control, needle_low, needle_high, haystack_low, haystack_high,
    // needle_length, haystack_length, zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // match_index, mask_low, mask_high, carry_flag, zero_flag, sign_flag,
    // overflow_flag, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata
);
    logic         action;
    logic [7:0]   control;
    logic [127:0] needle;
    logic [127:0] hay;
    logic [31:0]  nlen;
    logic [31:0]  hlen;

    assign action  = s_tdata[0];
    assign control = s_tdata[8:1];
    assign needle  = s_tdata[136:9];
    assign hay     = s_tdata[264:137];
    assign nlen    = s_tdata[296:265];
    assign hlen    = s_tdata[328:297];

    // pipeline valids: stage 1 (decode), stage 2 (cells), out + skid
    logic v1_reg, v2_reg, out_v_reg, skid_v_reg;
    logic adv;
    logic [OUT_TDATA_W-1:0] out_reg, skid_reg, fin_word;

    // advance while the skid slot is free
    assign adv = !skid_v_reg;
    assign s_tready = adv;

    // ---------- stage 1: decode and lengths ----------
    logic [4:0] n_in;
    logic       words_in, sgn_in;
    logic [NUM_ELEM*17-1:0] av_next, bv_next, av_reg, bv_reg;
    logic [4:0] la_next, lb_next;
    psc_op_t    op1_reg, op1_next;

    function automatic logic [4:0] sat_len(input logic [31:0] x, input logic [4:0] n);
        logic [31:0] mag;
        begin
            mag = x[31] ? (~x + 32'd1) : x;
            return (mag > 32'(n)) ? n : mag[4:0];
        end
    endfunction

    always_comb
    begin
        words_in = control[0];
        sgn_in = control[1];
        n_in = words_in ? 5'd8 : 5'd16;
        for (int i = 0; i < NUM_ELEM; i++)
        begin
            av_next[i*17 +: 17] = elem_val(needle, i, words_in, sgn_in);
            bv_next[i*17 +: 17] = elem_val(hay, i, words_in, sgn_in);
        end
        la_next = n_in;
        lb_next = n_in;
        for (int i = NUM_ELEM - 1; i >= 0; i--)
        begin
            if (5'(i) < n_in && av_next[i*17 +: 17] == '0)
                la_next = 5'(i);
            if (5'(i) < n_in && bv_next[i*17 +: 17] == '0)
                lb_next = 5'(i);
        end
        if (action)
        begin
            la_next = sat_len(nlen, n_in);
            lb_next = sat_len(hlen, n_in);
        end
        op1_next.words = words_in;
        op1_next.agg = control[3:2];
        op1_next.pol = control[5:4];
        op1_next.hisel = control[6];
        op1_next.la = la_next;
        op1_next.lb = lb_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            av_reg <= av_next;
            bv_reg <= bv_next;
            op1_reg <= op1_next;
        end
    end

    // ---------- stage 2: row of cells ----------
    logic [NUM_ELEM-1:0] hits;
    psc_op_t op2_reg;

    for (genvar j = 0; j < NUM_ELEM; j++)
    begin : g_cell
        logic [NUM_ELEM-1:0] eq_ord;
        always_comb
        begin
            for (int i = 0; i < NUM_ELEM; i++)
                eq_ord[i] = (i + j < NUM_ELEM) ?
                    (av_reg[i*17 +: 17] == bv_reg[((i + j) % NUM_ELEM)*17 +: 17]) : 1'b0;
        end
        psc_cell #(.IDX(j)) u_cell
        (
            .clk    (clk),
            .av     (av_reg),
            .bj     (signed'(bv_reg[j*17 +: 17])),
            .eq_ord (eq_ord),
            .op     (op1_reg),
            .hit    (hits[j])
        );
    end

    // cell outputs are registered; cells always load so gate on adv via hold
    logic [NUM_ELEM-1:0] hits_hold_reg;
    logic                adv_d_reg;
    logic [NUM_ELEM-1:0] res1;

    always_ff @(posedge clk)
    begin
        if (adv)
            op2_reg <= op1_reg;
        adv_d_reg <= adv;
        if (adv_d_reg)
            hits_hold_reg <= hits;
    end

    assign res1 = adv_d_reg ? hits : hits_hold_reg;

    logic [4:0]  mi;
    logic [63:0] ml, mh;
    logic        cf, zf, sf, of;

    psc_finish u_finish
    (
        .op            (op2_reg),
        .res1          (res1),
        .match_index   (mi),
        .mask_low      (ml),
        .mask_high     (mh),
        .carry_flag    (cf),
        .zero_flag     (zf),
        .sign_flag     (sf),
        .overflow_flag (of)
    );

    assign fin_word = OUT_TDATA_W'({of, sf, zf, cf, mh, ml, mi});

    // ---------- output register with skid ----------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            out_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (out_v_reg && m_tready)
            begin
                if (skid_v_reg)
                begin
                    out_reg <= skid_reg;
                    skid_v_reg <= 1'b0;
                end
                else if (!v2_reg)
                    out_v_reg <= 1'b0;
            end
            if (adv)
            begin
                v1_reg <= s_tvalid;
                v2_reg <= v1_reg;
                if (v2_reg)
                begin
                    if (!out_v_reg || (m_tready && !skid_v_reg))
                    begin
                        out_reg <= fin_word;
                        out_v_reg <= 1'b1;
                    end
                    else
                    begin
                        skid_reg <= fin_word;
                        skid_v_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata = out_reg;
endmodule
